// ===== sv/column_log_sum_with_floor_top_defines.svh =====
// assertion macros for the column log-sum block
`ifndef COLUMN_LOG_SUM_WITH_FLOOR_TOP_DEFINES_SVH
`define COLUMN_LOG_SUM_WITH_FLOOR_TOP_DEFINES_SVH

// clocked assertion that is switched off while reset is low
`define CLSF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define CLSF_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/clsf_pkg.sv =====
// shared constants, queue word type and log table function for the column log-sum block
package clsf_pkg;

    localparam int FRAC_BITS_DEF        = 20;
    localparam int TABLE_INDEX_BITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam int SAMPLE_W = 64;
    localparam int SUM_W    = 44;
    localparam int FLOOR_W  = 31;
    localparam int ADD_W    = 46;

    localparam logic signed [FLOOR_W-1:0] FLOOR_RESET = -31'sd779875176;
    localparam logic [31:0]               LN2_Q32     = 32'd2977044472;

    typedef struct packed {
        logic                    pinf;
        logic                    last;
        logic signed [ADD_W-1:0] add;
    } t_qword;

    // shift-subtract long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1 + i / 2^tib) in q.32 by the atanh series
    function automatic logic [31:0] ln_entry(input int unsigned idx, input int unsigned tib);
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        u    = 64'(idx) << (32 - tib);
        z    = udiv64(u << 31, (64'd8589934592 + u) >> 1);
        z2   = (z * z) >> 32;
        term = z;
        acc  = '0;
        for (int k = 1; k <= 41; k += 2) begin
            acc  = acc + udiv64(term, 64'(k));
            term = (term * z2) >> 32;
        end
        return 32'(acc << 1);
    endfunction

endpackage

// ===== sv/clsf_front.sv =====
// front pipeline: classify each double, normalise subnormals and compute the fixed-point log
module clsf_front import clsf_pkg::*; #(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [SAMPLE_W-1:0]       i_sample_bits,
    input  logic                      i_last,
    input  logic signed [FLOOR_W-1:0] i_floor_value,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output t_qword                    o_push_word
);

    localparam int FB        = 32 - TABLE_INDEX_BITS;
    localparam int ROM_DEPTH = (1 << TABLE_INDEX_BITS) + 1;
    localparam int ROM_AW    = TABLE_INDEX_BITS + 1;
    localparam int SH        = 32 - FRAC_BITS;
    localparam int NCHUNK    = 4;
    localparam int CHUNK_W   = 13;

    localparam logic signed [ADD_W-1:0] RND = ADD_W'((64'd1 << SH) >> 1);

    localparam logic [1:0] CLS_NORM  = 2'd0;
    localparam logic [1:0] CLS_SUB   = 2'd1;
    localparam logic [1:0] CLS_FLOOR = 2'd2;
    localparam logic [1:0] CLS_PINF  = 2'd3;

    typedef logic [31:0] t_rom [ROM_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = ln_entry(32'(i), 32'(TABLE_INDEX_BITS));
        end
        return rom;
    endfunction

    localparam t_rom LN_ROM = build_rom();

    logic w_adv;

    // stage 1: classify, per-chunk leading zeros
    logic        w_sign;
    logic [10:0] w_ex;
    logic [51:0] w_mant;
    logic [1:0]  w_cls;
    logic [CHUNK_W-1:0] w_chunk [NCHUNK];
    logic [NCHUNK-1:0]  w_nz;
    logic [3:0]         w_lzc [NCHUNK];

    logic        r_s1_valid;
    logic [1:0]  r_s1_cls;
    logic        r_s1_last;
    logic [10:0] r_s1_ex;
    logic [51:0] r_s1_mant;
    logic [NCHUNK-1:0] r_s1_nz;
    logic [3:0]        r_s1_lzc [NCHUNK];

    // stage 2: exponent and table index
    logic [5:0]         w_lz;
    logic [51:0]        w_f52;
    logic signed [11:0] w_e;

    logic                        r_s2_valid;
    logic [1:0]                  r_s2_cls;
    logic                        r_s2_last;
    logic signed [11:0]          r_s2_e;
    logic [TABLE_INDEX_BITS-1:0] r_s2_idx;
    logic [FB-1:0]               r_s2_fr;

    // stage 3: table read
    logic [ROM_AW-1:0] w_addr_lo;
    logic [ROM_AW-1:0] w_addr_hi;

    logic               r_s3_valid;
    logic [1:0]         r_s3_cls;
    logic               r_s3_last;
    logic signed [11:0] r_s3_e;
    logic [FB-1:0]      r_s3_fr;
    logic [31:0]        r_s3_lo;
    logic [31:0]        r_s3_hi;

    // stage 4: interpolation and exponent products
    logic [31:0]        w_diff;
    logic [FB+31:0]     w_prod;
    logic signed [44:0] w_eln;

    logic               r_s4_valid;
    logic [1:0]         r_s4_cls;
    logic               r_s4_last;
    logic signed [44:0] r_s4_eln;
    logic [31:0]        r_s4_lo;
    logic [31:0]        r_s4_interp;

    // stage 5: round, clamp, floor
    logic signed [ADD_W-1:0] w_q;
    logic signed [ADD_W-1:0] w_lg;
    logic signed [ADD_W-1:0] w_floor_x;
    logic signed [ADD_W-1:0] w_add;

    logic   r_s5_valid;
    t_qword r_s5_word;

    assign w_adv        = !r_s5_valid || i_push_ready;
    assign o_ready      = w_adv;
    assign o_push_valid = r_s5_valid;
    assign o_push_word  = r_s5_word;

    assign w_sign = i_sample_bits[63];
    assign w_ex   = i_sample_bits[62:52];
    assign w_mant = i_sample_bits[51:0];

    always_comb begin
        if (w_ex == 11'h7FF && w_mant == '0 && !w_sign) begin
            w_cls = CLS_PINF;
        end else if (w_sign || w_ex == 11'h7FF || (w_ex == '0 && w_mant == '0)) begin
            w_cls = CLS_FLOOR;
        end else if (w_ex == '0) begin
            w_cls = CLS_SUB;
        end else begin
            w_cls = CLS_NORM;
        end
    end

    always_comb begin
        for (int c = 0; c < NCHUNK; c++) begin
            w_chunk[c] = w_mant[51 - CHUNK_W * c -: CHUNK_W];
            w_nz[c]    = |w_chunk[c];
            w_lzc[c]   = '0;
            for (int j = 0; j < CHUNK_W; j++) begin
                if (w_chunk[c][j]) begin
                    w_lzc[c] = 4'(CHUNK_W - 1 - j);
                end
            end
        end
    end

    always_comb begin
        w_lz = '0;
        for (int c = NCHUNK - 1; c >= 0; c--) begin
            if (r_s1_nz[c]) begin
                w_lz = 6'(CHUNK_W * c + int'(r_s1_lzc[c]));
            end
        end
    end

    always_comb begin
        if (r_s1_cls == CLS_SUB) begin
            w_f52 = 52'(r_s1_mant << (w_lz + 6'd1));
            w_e   = -12'sd1023 - $signed({6'b0, w_lz});
        end else begin
            w_f52 = r_s1_mant;
            w_e   = $signed({1'b0, r_s1_ex}) - 12'sd1023;
        end
    end

    assign w_addr_lo = {1'b0, r_s2_idx};
    assign w_addr_hi = {1'b0, r_s2_idx} + ROM_AW'(1);

    assign w_diff = r_s3_hi - r_s3_lo;
    assign w_prod = (FB + 32)'(w_diff) * (FB + 32)'(r_s3_fr);
    assign w_eln  = $signed(45'(r_s3_e)) * $signed({13'b0, LN2_Q32});

    assign w_q = ADD_W'(r_s4_eln)
               + $signed({{(ADD_W - 32){1'b0}}, r_s4_lo})
               + $signed({{(ADD_W - 32){1'b0}}, r_s4_interp});
    assign w_lg      = (w_q + RND) >>> SH;
    assign w_floor_x = ADD_W'(i_floor_value);
    assign w_add     = (r_s4_cls == CLS_FLOOR || w_lg < w_floor_x) ? w_floor_x : w_lg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cls  <= w_cls;
            r_s1_last <= i_last;
            r_s1_ex   <= w_ex;
            r_s1_mant <= w_mant;
            r_s1_nz   <= w_nz;
            r_s1_lzc  <= w_lzc;

            r_s2_cls  <= r_s1_cls;
            r_s2_last <= r_s1_last;
            r_s2_e    <= w_e;
            r_s2_idx  <= w_f52[51 -: TABLE_INDEX_BITS];
            r_s2_fr   <= w_f52[20 +: FB];

            r_s3_cls  <= r_s2_cls;
            r_s3_last <= r_s2_last;
            r_s3_e    <= r_s2_e;
            r_s3_fr   <= r_s2_fr;
            r_s3_lo   <= LN_ROM[w_addr_lo];
            r_s3_hi   <= LN_ROM[w_addr_hi];

            r_s4_cls    <= r_s3_cls;
            r_s4_last   <= r_s3_last;
            r_s4_eln    <= w_eln;
            r_s4_lo     <= r_s3_lo;
            r_s4_interp <= w_prod[FB+31:FB];

            r_s5_word.pinf <= (r_s4_cls == CLS_PINF);
            r_s5_word.last <= r_s4_last;
            r_s5_word.add  <= w_add;
        end
    end

endmodule

// ===== sv/clsf_queue.sv =====
// small word queue between the log front end and the accumulator
module clsf_queue import clsf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_valid,
    output logic   o_wr_ready,
    input  t_qword i_wr_word,
    output logic   o_rd_valid,
    input  logic   i_rd_ready,
    output t_qword o_rd_word
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_qword             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_word  = r_mem[r_rd_ptr];
    assign w_wr       = i_wr_valid && o_wr_ready;
    assign w_rd       = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(w_wr) - CNT_W'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_word;
        end
    end

endmodule

// ===== sv/clsf_back.sv =====
// back end: saturating column accumulator and result register
module clsf_back import clsf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_word_valid,
    output logic                    o_word_ready,
    input  t_qword                  i_word,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [SUM_W-1:0] o_log_sum,
    output logic                    o_saturated
);

    localparam int SW = ADD_W + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    logic signed [SUM_W-1:0] r_sum;
    logic                    r_ovf;
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_log_sum;
    logic                    r_saturated;

    logic signed [SUM_W-1:0] n_sum;
    logic                    n_ovf;
    logic signed [SW-1:0]    w_s;
    logic                    w_pop;

    assign o_word_ready = !i_word.last || !r_out_valid || i_ready;
    assign w_pop        = i_word_valid && o_word_ready;
    assign w_s          = SW'(r_sum) + SW'($signed(i_word.add));

    assign o_valid     = r_out_valid;
    assign o_log_sum   = r_log_sum;
    assign o_saturated = r_saturated;

    always_comb begin
        if (i_word.pinf) begin
            n_sum = SUM_MAX;
            n_ovf = 1'b1;
        end else if (w_s > SW'(SUM_MAX)) begin
            n_sum = SUM_MAX;
            n_ovf = 1'b1;
        end else if (w_s < SW'(SUM_MIN)) begin
            n_sum = SUM_MIN;
            n_ovf = 1'b1;
        end else begin
            n_sum = w_s[SUM_W-1:0];
            n_ovf = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                if (i_word.last) begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_ovf <= n_ovf;
                end
            end
            if (w_pop && i_word.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_word.last) begin
            r_log_sum   <= n_sum;
            r_saturated <= n_ovf;
        end
    end

endmodule

// ===== sv/column_log_sum_with_floor_top.sv =====
// top level: column log-sum of ieee double words into a saturating q23.20 sum
// path: a last word passes the five front stages, the queue and the result register to o_valid
// throughput: one word per cycle unless the queue fills or a last word waits on a held result
// reset: synchronous active low; clears pipeline, queue, sum and flag, reloads the floor register
module column_log_sum_with_floor_top import clsf_pkg::*; #(
    parameter int FRAC_BITS        = FRAC_BITS_DEF,
    parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [SAMPLE_W-1:0]       i_sample_bits,
    input  logic                      i_last,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [SUM_W-1:0]   o_log_sum,
    output logic                      o_saturated,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic signed [FLOOR_W-1:0] i_floor_value
);

    logic signed [FLOOR_W-1:0] r_floor;

    logic   w_push_valid;
    logic   w_push_ready;
    t_qword w_push_word;
    logic   w_pop_valid;
    logic   w_pop_ready;
    t_qword w_pop_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RESET;
        end else if (i_cfg_valid) begin
            r_floor <= i_floor_value;
        end
    end

    clsf_front #(
        .FRAC_BITS        (FRAC_BITS),
        .TABLE_INDEX_BITS (TABLE_INDEX_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample_bits (i_sample_bits),
        .i_last        (i_last),
        .i_floor_value (r_floor),
        .o_push_valid  (w_push_valid),
        .i_push_ready  (w_push_ready),
        .o_push_word   (w_push_word)
    );

    clsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_word  (w_push_word),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_word  (w_pop_word)
    );

    clsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_word_valid (w_pop_valid),
        .o_word_ready (w_pop_ready),
        .i_word       (w_pop_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_log_sum    (o_log_sum),
        .o_saturated  (o_saturated)
    );

endmodule

// ===== sv/clsf_checker.sv =====
// port-level checker for the column log-sum top, bound to it
`include "column_log_sum_with_floor_top_defines.svh"

module clsf_checker import clsf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic signed [SUM_W-1:0] o_log_sum,
    input logic                    o_saturated
);

    `CLSF_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_log_sum) && $stable(o_saturated), "result word lost or changed while stalled")
    `CLSF_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_valid, "result word valid straight after reset")
    `CLSF_ASSERT_RST(a_rst_ready, i_clk, !i_rst_n |=> o_ready, "input not ready straight after reset")

endmodule

bind column_log_sum_with_floor_top clsf_checker u_clsf_checker (.*);
